/* rtl/rational_arithmetic_unit_macros.svh */
// assertion helpers shared by the checker
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rau check failed");

`endif

/* rtl/rau_pkg.sv */
`default_nettype none
package rau_pkg;

	localparam logic [2:0] OP_REDUCE   = 3'd0;
	localparam logic [2:0] OP_ADD      = 3'd1;
	localparam logic [2:0] OP_SUBTRACT = 3'd2;
	localparam logic [2:0] OP_MULTIPLY = 3'd3;
	localparam logic [2:0] OP_DIVIDE   = 3'd4;
	localparam logic [2:0] OP_EQUAL    = 3'd5;
	localparam logic [2:0] OP_LESS     = 3'd6;
	localparam logic [2:0] OP_UNUSED   = 3'd7;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef enum logic {
		MODE_MUL,
		MODE_DIV
	} mode_t;

	typedef struct packed {
		logic  start;
		mode_t mode;
		logic  short_div;
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RED,
		ST_RED_N,
		ST_RED_D,
		ST_RED_W,
		ST_RED_END,
		ST_DISP,
		ST_CMP_P,
		ST_CMP_Q,
		ST_M_G1,
		ST_M_G2,
		ST_M_Q1,
		ST_M_Q2,
		ST_M_Q3,
		ST_M_Q4,
		ST_M_P1,
		ST_M_P2,
		ST_S_G,
		ST_S_Q1,
		ST_S_Q2,
		ST_S_P1,
		ST_S_P2,
		ST_S_R,
		ST_S_G2,
		ST_S_N,
		ST_S_D,
		ST_S_F,
		ST_GCD,
		ST_GCD_STEP,
		ST_WAIT,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

/* rtl/rational_arithmetic_unit.sv */
// fraction alu: op plus two fractions in, one reduced fraction out
// input channel s_axis_*: one transaction carries op, a_num, a_den, b_num, b_den
// output channel m_axis_*: one transaction per input with res_num, res_den,
//   cmp_true and status (0 ok, 1 zero denominator, 2 overflow)
// every multiply and every short or long (2*WIDTH bit) divide runs on the
// one shared shift/add unit; operand reduction costs one short divide per
// Euclid step plus two, while errors and opcode 7 go straight to the
// result without any unit call
// one item in flight: s_axis_tready is high only while the sequencer idles
// the finished result sits in an output register, so a new item is taken
// while the receiver stalls; the sequencer then holds its next result
// until that register frees up
// reset clears the sequencer and the output valid; no state carries over
`default_nettype none
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// op, a_num, a_den, b_num, b_den
	input  wire [((3+4*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// res_num, res_den, cmp_true, status
	output logic [((2*WIDTH+2+7)/8)*8-1:0]        m_axis_tdata
);
	import rau_pkg::*;

	localparam int W2       = 2 * WIDTH;
	localparam int OUT_BITS = ((2 * WIDTH + 2 + 7) / 8) * 8;
	localparam logic [W2-1:0] HALF = W2'(1) << (WIDTH - 1);

	state_t state_q, state_d, ret_q, ret_d, gret_q, gret_d;
	logic gcd_call;
	logic [WIDTH-1:0] gcd_x, gcd_y;

	logic [2:0]       op_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q, g_q, y_q, gx_q, gy_q;
	logic             aneg_q, bneg_q, rneg_q, err_q, sel_q;
	logic [W2-1:0]    x_q, t_q;
	logic [WIDTH-1:0] rn_q;
	logic [WIDTH-2:0] rd_q;
	logic             rc_q;
	logic [1:0]       rs_q;
	logic             out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	cmd_t             cmd;
	logic [W2-1:0]    u_opa;
	logic [WIDTH-1:0] u_opb;
	logic [W2-1:0]    u_res;
	logic [WIDTH-1:0] u_rem;
	logic             u_done;

	logic [2:0]       in_op;
	logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd, abs_an, abs_ad, abs_bn, abs_bd;
	logic [WIDTH-1:0] sel_num, sel_den;
	logic [W2-1:0]    t_calc;
	logic             rneg_calc, sb, cmp_res;
	logic [W2-1:0]    fr_num, fr_den, fr_lim;
	logic             fr_neg, fr_ovf;
	logic [WIDTH-1:0] fr_out;

	rau_arith #(.WIDTH(WIDTH)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (u_opa),
		.opb    (u_opb),
		.res    (u_res),
		.rem    (u_rem),
		.done   (u_done)
	);

	always_comb begin
		in_op  = s_axis_tdata[2:0];
		in_an  = s_axis_tdata[3 +: WIDTH];
		in_ad  = s_axis_tdata[3+WIDTH +: WIDTH];
		in_bn  = s_axis_tdata[3+2*WIDTH +: WIDTH];
		in_bd  = s_axis_tdata[3+3*WIDTH +: WIDTH];
		abs_an = in_an[WIDTH-1] ? (~in_an + 1'b1) : in_an;
		abs_ad = in_ad[WIDTH-1] ? (~in_ad + 1'b1) : in_ad;
		abs_bn = in_bn[WIDTH-1] ? (~in_bn + 1'b1) : in_bn;
		abs_bd = in_bd[WIDTH-1] ? (~in_bd + 1'b1) : in_bd;

		sel_num = sel_q ? bn_q : an_q;
		sel_den = sel_q ? bd_q : ad_q;

		sb = (bn_q == '0) ? 1'b0 : ((op_q == OP_SUBTRACT) ? !bneg_q : bneg_q);

		// signed sum of the two cross terms, kept as sign and magnitude
		if (aneg_q == bneg_q) begin
			t_calc    = x_q + u_res;
			rneg_calc = aneg_q;
		end else if (x_q >= u_res) begin
			t_calc    = x_q - u_res;
			rneg_calc = aneg_q;
		end else begin
			t_calc    = u_res - x_q;
			rneg_calc = bneg_q;
		end

		if (op_q == OP_EQUAL) begin
			cmp_res = (aneg_q == bneg_q) && (x_q == u_res);
		end else if (aneg_q != bneg_q) begin
			cmp_res = aneg_q;
		end else begin
			cmp_res = aneg_q ? (x_q > u_res) : (x_q < u_res);
		end

		case (state_q)
			ST_M_P2: begin
				fr_num = x_q;
				fr_den = u_res;
				fr_neg = aneg_q ^ bneg_q;
			end
			ST_S_F: begin
				fr_num = t_q;
				fr_den = u_res;
				fr_neg = rneg_q;
			end
			default: begin
				fr_num = {{WIDTH{1'b0}}, an_q};
				fr_den = {{WIDTH{1'b0}}, ad_q};
				fr_neg = aneg_q;
			end
		endcase
		fr_lim = fr_neg ? HALF : HALF - 1'b1;
		fr_ovf = (fr_num > fr_lim) || (fr_den > HALF - 1'b1);
		fr_out = fr_neg ? (~fr_num[WIDTH-1:0] + 1'b1) : fr_num[WIDTH-1:0];
	end

	// next state and unit commands
	always_comb begin
		state_d       = state_q;
		ret_d         = ret_q;
		gret_d        = gret_q;
		gcd_call      = 1'b0;
		gcd_x         = '0;
		gcd_y         = '0;
		cmd.start     = 1'b0;
		cmd.mode      = MODE_MUL;
		cmd.short_div = 1'b1;
		u_opa         = '0;
		u_opb         = '0;
		s_axis_tready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (op_q == OP_UNUSED || err_q) state_d = ST_FIN;
				else state_d = ST_RED;
			end
			ST_RED: begin
				if (sel_num == '0) begin
					state_d = ST_RED_END;
				end else begin
					gcd_call = 1'b1;
					gcd_x    = sel_num;
					gcd_y    = sel_den;
					gret_d   = ST_RED_N;
					state_d  = ST_GCD;
				end
			end
			ST_RED_N, ST_RED_D: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, (state_q == ST_RED_N) ? sel_num : sel_den};
				u_opb     = gx_q;
				ret_d     = (state_q == ST_RED_N) ? ST_RED_D : ST_RED_W;
				state_d   = ST_WAIT;
			end
			ST_RED_W: state_d = ST_RED_END;
			ST_RED_END: begin
				if (sel_q) state_d = ST_DISP;
				else if (op_q == OP_REDUCE) state_d = ST_FIN;
				else state_d = ST_RED;
			end
			ST_DISP: begin
				case (op_q)
					OP_EQUAL, OP_LESS: begin
						cmd.start = 1'b1;
						u_opa     = {{WIDTH{1'b0}}, an_q};
						u_opb     = bd_q;
						ret_d     = ST_CMP_P;
						state_d   = ST_WAIT;
					end
					OP_DIVIDE: state_d = ST_DISP;
					OP_MULTIPLY: begin
						if (an_q == '0 || bn_q == '0) begin
							state_d = ST_FIN;
						end else begin
							gcd_call = 1'b1;
							gcd_x    = an_q;
							gcd_y    = bd_q;
							gret_d   = ST_M_G1;
							state_d  = ST_GCD;
						end
					end
					default: begin
						gcd_call = 1'b1;
						gcd_x    = ad_q;
						gcd_y    = bd_q;
						gret_d   = ST_S_G;
						state_d  = ST_GCD;
					end
				endcase
			end
			ST_CMP_P: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, bn_q};
				u_opb     = ad_q;
				ret_d     = ST_CMP_Q;
				state_d   = ST_WAIT;
			end
			ST_CMP_Q, ST_M_P2, ST_S_F: state_d = ST_FIN;
			ST_M_G1: begin
				gcd_call = 1'b1;
				gcd_x    = bn_q;
				gcd_y    = ad_q;
				gret_d   = ST_M_G2;
				state_d  = ST_GCD;
			end
			ST_M_G2: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, an_q};
				u_opb     = g_q;
				ret_d     = ST_M_Q1;
				state_d   = ST_WAIT;
			end
			ST_M_Q1: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, bd_q};
				u_opb     = g_q;
				ret_d     = ST_M_Q2;
				state_d   = ST_WAIT;
			end
			ST_M_Q2: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, bn_q};
				u_opb     = y_q;
				ret_d     = ST_M_Q3;
				state_d   = ST_WAIT;
			end
			ST_M_Q3: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, ad_q};
				u_opb     = y_q;
				ret_d     = ST_M_Q4;
				state_d   = ST_WAIT;
			end
			ST_M_Q4: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, an_q};
				u_opb     = bn_q;
				ret_d     = ST_M_P1;
				state_d   = ST_WAIT;
			end
			ST_M_P1: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, ad_q};
				u_opb     = bd_q;
				ret_d     = ST_M_P2;
				state_d   = ST_WAIT;
			end
			ST_S_G: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, bd_q};
				u_opb     = gx_q;
				ret_d     = ST_S_Q1;
				state_d   = ST_WAIT;
			end
			ST_S_Q1: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, ad_q};
				u_opb     = g_q;
				ret_d     = ST_S_Q2;
				state_d   = ST_WAIT;
			end
			ST_S_Q2: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, an_q};
				u_opb     = y_q;
				ret_d     = ST_S_P1;
				state_d   = ST_WAIT;
			end
			ST_S_P1: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, bn_q};
				u_opb     = ad_q;
				ret_d     = ST_S_P2;
				state_d   = ST_WAIT;
			end
			ST_S_P2: begin
				if (t_calc == '0) begin
					state_d = ST_FIN;
				end else begin
					cmd.start     = 1'b1;
					cmd.mode      = MODE_DIV;
					cmd.short_div = 1'b0;
					u_opa         = t_calc;
					u_opb         = g_q;
					ret_d         = ST_S_R;
					state_d       = ST_WAIT;
				end
			end
			ST_S_R: begin
				gcd_call = 1'b1;
				gcd_x    = g_q;
				gcd_y    = u_rem;
				gret_d   = ST_S_G2;
				state_d  = ST_GCD;
			end
			ST_S_G2: begin
				cmd.start     = 1'b1;
				cmd.mode      = MODE_DIV;
				cmd.short_div = 1'b0;
				u_opa         = t_q;
				u_opb         = gx_q;
				ret_d         = ST_S_N;
				state_d       = ST_WAIT;
			end
			ST_S_N: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_DIV;
				u_opa     = {{WIDTH{1'b0}}, bd_q};
				u_opb     = gx_q;
				ret_d     = ST_S_D;
				state_d   = ST_WAIT;
			end
			ST_S_D: begin
				cmd.start = 1'b1;
				u_opa     = {{WIDTH{1'b0}}, ad_q};
				u_opb     = u_res[WIDTH-1:0];
				ret_d     = ST_S_F;
				state_d   = ST_WAIT;
			end
			ST_GCD: begin
				if (gy_q == '0) begin
					state_d = gret_q;
				end else begin
					cmd.start = 1'b1;
					cmd.mode  = MODE_DIV;
					u_opa     = {{WIDTH{1'b0}}, gx_q};
					u_opb     = gy_q;
					ret_d     = ST_GCD_STEP;
					state_d   = ST_WAIT;
				end
			end
			ST_GCD_STEP: state_d = ST_GCD;
			ST_WAIT: begin
				if (u_done) state_d = ret_q;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			gret_q  <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			gret_q  <= gret_d;
		end
	end

	always_ff @(posedge clk) begin
		if (gcd_call) begin
			gx_q <= gcd_x;
			gy_q <= gcd_y;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_q   <= in_op;
					an_q   <= abs_an;
					ad_q   <= (in_an == '0) ? WIDTH'(1) : abs_ad;
					aneg_q <= (in_an != '0) && (in_an[WIDTH-1] ^ in_ad[WIDTH-1]);
					bn_q   <= abs_bn;
					bd_q   <= (in_bn == '0) ? WIDTH'(1) : abs_bd;
					bneg_q <= (in_bn != '0) && (in_bn[WIDTH-1] ^ in_bd[WIDTH-1]);
					err_q  <= (in_ad == '0) || (in_op != OP_REDUCE && in_bd == '0) ||
						(in_op == OP_DIVIDE && in_bn == '0);
				end
			end
			ST_CHECK: begin
				sel_q <= 1'b0;
				rn_q  <= '0;
				rc_q  <= 1'b0;
				if (op_q == OP_UNUSED) begin
					rd_q <= (WIDTH-1)'(1);
					rs_q <= STAT_OK;
				end else begin
					rd_q <= '0;
					rs_q <= STAT_ZERO_DEN;
				end
			end
			ST_RED_D: begin
				if (sel_q) bn_q <= u_res[WIDTH-1:0];
				else an_q <= u_res[WIDTH-1:0];
			end
			ST_RED_W: begin
				if (sel_q) bd_q <= u_res[WIDTH-1:0];
				else ad_q <= u_res[WIDTH-1:0];
			end
			ST_RED_END, ST_M_P2, ST_S_F: begin
				sel_q <= 1'b1;
				rc_q  <= 1'b0;
				if (fr_ovf) begin
					rn_q <= '0;
					rd_q <= '0;
					rs_q <= STAT_OVERFLOW;
				end else begin
					rn_q <= fr_out;
					rd_q <= fr_den[WIDTH-2:0];
					rs_q <= STAT_OK;
				end
			end
			ST_DISP: begin
				rn_q <= '0;
				rd_q <= (WIDTH-1)'(1);
				rc_q <= 1'b0;
				rs_q <= STAT_OK;
				if (op_q == OP_DIVIDE) begin
					// multiply by the reciprocal of b
					bn_q <= bd_q;
					bd_q <= bn_q;
					op_q <= OP_MULTIPLY;
				end else if (op_q == OP_ADD || op_q == OP_SUBTRACT) begin
					bneg_q <= sb;
				end
			end
			ST_CMP_P, ST_M_P1, ST_S_P1: x_q <= u_res;
			ST_CMP_Q: rc_q <= cmp_res;
			ST_M_G1, ST_S_G: g_q <= gx_q;
			ST_M_G2: y_q <= gx_q;
			ST_M_Q1: an_q <= u_res[WIDTH-1:0];
			ST_M_Q2: bd_q <= u_res[WIDTH-1:0];
			ST_M_Q3: bn_q <= u_res[WIDTH-1:0];
			ST_M_Q4, ST_S_Q2: ad_q <= u_res[WIDTH-1:0];
			ST_S_Q1: y_q <= u_res[WIDTH-1:0];
			ST_S_P2: begin
				t_q    <= t_calc;
				rneg_q <= rneg_calc;
			end
			ST_S_N: t_q <= u_res;
			ST_GCD_STEP: begin
				gx_q <= gy_q;
				gy_q <= u_rem;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= OUT_BITS'({rs_q, rc_q, rd_q, rn_q});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* rtl/rau_arith.sv */
`default_nettype none
module rau_arith #(
	parameter int WIDTH = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rau_pkg::cmd_t         cmd,
	input  wire [2*WIDTH-1:0]     opa,
	input  wire [WIDTH-1:0]       opb,
	output logic [2*WIDTH-1:0]    res,
	output logic [WIDTH-1:0]      rem,
	output logic                  done
);
	import rau_pkg::*;

	localparam int CW = $clog2(2 * WIDTH + 1);

	logic [2*WIDTH-1:0] acc_q;
	logic [WIDTH-1:0]   md_q;
	logic [WIDTH-1:0]   mq_q;
	logic [WIDTH-1:0]   r_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	mode_t              mode_q;

	logic [WIDTH:0]     msum;
	logic [WIDTH:0]     rs;
	logic [WIDTH:0]     rdiff;
	logic               ge;

	always_comb begin
		msum  = {1'b0, acc_q[2*WIDTH-1:WIDTH]} + (mq_q[0] ? {1'b0, md_q} : '0);
		rs    = {r_q, acc_q[2*WIDTH-1]};
		rdiff = rs - {1'b0, md_q};
		ge    = rs >= {1'b0, md_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			mode_q <= MODE_MUL;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			mode_q <= cmd.mode;
			if (cmd.mode == MODE_MUL || cmd.short_div) begin
				cnt_q <= CW'(WIDTH);
			end else begin
				cnt_q <= CW'(2 * WIDTH);
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			md_q <= (cmd.mode == MODE_MUL) ? opa[WIDTH-1:0] : opb;
			mq_q <= opb;
			r_q  <= '0;
			if (cmd.mode == MODE_MUL) begin
				acc_q <= '0;
			end else if (cmd.short_div) begin
				// narrow dividend sits on top so only its bits are walked
				acc_q <= {opa[WIDTH-1:0], {WIDTH{1'b0}}};
			end else begin
				acc_q <= opa;
			end
		end else if (busy_q) begin
			if (mode_q == MODE_MUL) begin
				acc_q <= {msum, acc_q[WIDTH-1:1]};
				mq_q  <= mq_q >> 1;
			end else begin
				r_q   <= ge ? rdiff[WIDTH-1:0] : rs[WIDTH-1:0];
				acc_q <= {acc_q[2*WIDTH-2:0], ge};
			end
		end
	end

	assign res  = acc_q;
	assign rem  = r_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* rtl/rau_chk.sv */
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"
module rau_chk #(
	parameter int WIDTH = 32
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_axis_tvalid,
	input wire                              s_axis_tready,
	input wire [((3+4*WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	input wire                              m_axis_tvalid,
	input wire                              m_axis_tready,
	input wire [((2*WIDTH+2+7)/8)*8-1:0]    m_axis_tdata
);
	import rau_pkg::*;

	logic [WIDTH-1:0] num;
	logic [WIDTH-2:0] den;
	logic             cmp;
	logic [1:0]       stat;
	logic             in_seen;

	assign num     = m_axis_tdata[WIDTH-1:0];
	assign den     = m_axis_tdata[2*WIDTH-2:WIDTH];
	assign cmp     = m_axis_tdata[2*WIDTH-1];
	assign stat    = m_axis_tdata[2*WIDTH+1:2*WIDTH];
	assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0 || 1'b1);

	`RAU_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`RAU_ASSERT_NOW(a_err_zero, clk, arst_n, m_axis_tvalid && stat != STAT_OK,
		num == '0 && den == '0 && !cmp)
	`RAU_ASSERT_NOW(a_cmp_form, clk, arst_n, m_axis_tvalid && cmp,
		num == '0 && den == (WIDTH-1)'(1) && stat == STAT_OK)
	`RAU_ASSERT_NOW(a_den_pos, clk, arst_n, m_axis_tvalid && stat == STAT_OK, den != '0)
	`RAU_ASSERT_NXT(a_one_busy, clk, arst_n, in_seen, !s_axis_tready)

endmodule

bind rational_arithmetic_unit rau_chk #(.WIDTH(WIDTH)) u_rau_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import rau_pkg::*;

	localparam int WIDTH = 32;
	localparam int IN_W = ((3 + 4 * WIDTH + 7) / 8) * 8;
	localparam int OUT_W = ((2 * WIDTH + 2 + 7) / 8) * 8;
	localparam int STALL_LIMIT = 40000;
	localparam logic [127:0] DEN_MAX = (128'd1 << (WIDTH - 1)) - 1;

	typedef struct packed {
		logic [2:0]        op;
		logic [WIDTH-1:0]  a_num;
		logic [WIDTH-1:0]  a_den;
		logic [WIDTH-1:0]  b_num;
		logic [WIDTH-1:0]  b_den;
	} fraction_op_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              cmp_true;
		logic [WIDTH-2:0]  res_den;
		logic [WIDTH-1:0]  res_num;
	} fraction_res_t;

	typedef struct {
		logic        neg;
		logic [63:0] n;
		logic [63:0] d;
	} fraction_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	fraction_op_t  pending_ops[$];
	fraction_res_t expected_results[$];
	int            error_count = 0;
	int            idle_cycles = 0;
	int            send_gap = 0;
	int            recv_gap = 0;
	logic          send_burst = 1'b0;
	logic          recv_burst = 1'b0;

	rational_arithmetic_unit #(.WIDTH(WIDTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic queue_op(fraction_op_t t);
		pending_ops = {pending_ops, t};
	endtask

	task automatic queue_expected(fraction_res_t r);
		expected_results = {expected_results, r};
	endtask

	// op in the lowest bits, then a_num, a_den, b_num, b_den
	function automatic logic [IN_W-1:0] to_bus(fraction_op_t t);
		return IN_W'({t.b_den, t.b_num, t.a_den, t.a_num, t.op});
	endfunction

	function automatic fraction_op_t from_bus(logic [IN_W-1:0] v);
		fraction_op_t t;
		t.op    = v[2:0];
		t.a_num = v[3 +: WIDTH];
		t.a_den = v[3+WIDTH +: WIDTH];
		t.b_num = v[3+2*WIDTH +: WIDTH];
		t.b_den = v[3+3*WIDTH +: WIDTH];
		return t;
	endfunction

	function automatic logic [63:0] gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic fraction_t lowest_terms(logic [WIDTH-1:0] num, logic [WIDTH-1:0] den);
		fraction_t f;
		logic [63:0] g;
		f.n = num[WIDTH-1] ? 64'(-num) & ((64'd1 << WIDTH) - 1) : 64'(num);
		f.d = den[WIDTH-1] ? 64'(-den) & ((64'd1 << WIDTH) - 1) : 64'(den);
		if (f.n == 0) begin
			f.neg = 1'b0;
			f.d = 1;
			return f;
		end
		f.neg = num[WIDTH-1] ^ den[WIDTH-1];
		g = gcd(f.n, f.d);
		f.n = f.n / g;
		f.d = f.d / g;
		return f;
	endfunction

	function automatic logic [127:0] num_limit(logic neg);
		return neg ? (128'd1 << (WIDTH - 1)) : DEN_MAX;
	endfunction

	function automatic fraction_res_t pack_result(logic neg, logic [127:0] n,
			logic [127:0] d, logic [1:0] status, logic cmp);
		fraction_res_t r;
		r = '0;
		r.status = status;
		if (n == 0 && status == STAT_OK) begin
			neg = 1'b0;
			d = 1;
		end
		if (status == STAT_OK && (n > num_limit(neg) || d > DEN_MAX))
			r.status = STAT_OVERFLOW;
		if (r.status == STAT_OK) begin
			r.res_num = neg ? WIDTH'(-n) : WIDTH'(n);
			r.res_den = d[WIDTH-2:0];
			r.cmp_true = cmp;
		end
		return r;
	endfunction

	function automatic fraction_res_t predict_fraction(fraction_op_t t);
		fraction_t a, b;
		logic [63:0] g, g1, g2, tmp;
		logic [127:0] x, y, p, q, mag;
		logic sb, neg, hit;
		a = lowest_terms(t.a_num, t.a_den);
		b = lowest_terms(t.b_num, t.b_den);
		if (t.op == OP_UNUSED)
			return pack_result(1'b0, 0, 1, STAT_OK, 1'b0);
		if (t.a_den == 0 || (t.op != OP_REDUCE && t.b_den == 0) ||
				(t.op == OP_DIVIDE && t.b_num == 0))
			return pack_result(1'b0, 0, 0, STAT_ZERO_DEN, 1'b0);
		case (t.op)
			OP_REDUCE: return pack_result(a.neg, a.n, a.d, STAT_OK, 1'b0);
			OP_EQUAL, OP_LESS: begin
				p = 128'(a.n) * 128'(b.d);
				q = 128'(b.n) * 128'(a.d);
				if (t.op == OP_EQUAL) hit = (a.neg == b.neg) && (p == q);
				else if (a.neg != b.neg) hit = a.neg;
				else hit = a.neg ? (p > q) : (p < q);
				return pack_result(1'b0, 0, 1, STAT_OK, hit);
			end
			OP_MULTIPLY, OP_DIVIDE: begin
				if (t.op == OP_DIVIDE) begin
					tmp = b.n;
					b.n = b.d;
					b.d = tmp;
				end
				if (a.n == 0 || b.n == 0)
					return pack_result(1'b0, 0, 1, STAT_OK, 1'b0);
				g1 = gcd(a.n, b.d);
				g2 = gcd(b.n, a.d);
				p = 128'(a.n / g1) * 128'(b.n / g2);
				q = 128'(a.d / g2) * 128'(b.d / g1);
				return pack_result(a.neg ^ b.neg, p, q, STAT_OK, 1'b0);
			end
			default: begin
				// add and subtract on a common denominator, then reduce
				sb = (t.op == OP_SUBTRACT) ? !b.neg : b.neg;
				if (b.n == 0) sb = 1'b0;
				g = gcd(a.d, b.d);
				x = 128'(a.n) * 128'(b.d / g);
				y = 128'(b.n) * 128'(a.d / g);
				if (a.neg == sb) begin
					mag = x + y;
					neg = a.neg;
				end else if (x >= y) begin
					mag = x - y;
					neg = a.neg;
				end else begin
					mag = y - x;
					neg = sb;
				end
				if (mag == 0)
					return pack_result(1'b0, 0, 1, STAT_OK, 1'b0);
				g2 = gcd(g, 64'(mag % 128'(g)));
				p = mag / 128'(g2);
				q = 128'(a.d / g) * 128'(b.d / g2);
				return pack_result(neg, p, q, STAT_OK, 1'b0);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				queue_expected(predict_fraction(from_bus(s_axis_tdata)));
			if (!s_axis_tvalid || s_axis_tready) begin
				if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= to_bus(pending_ops.pop_front());
					send_gap = send_burst ? 0 : pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		fraction_res_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = fraction_res_t'(m_axis_tdata[2*WIDTH+1:0]);
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected transaction", 64'(got), 0);
				end else begin
					want = expected_results.pop_front();
					if (got.res_num != want.res_num)
						report_mismatch("res_num", got.res_num, want.res_num);
					if (got.res_den != want.res_den)
						report_mismatch("res_den", got.res_den, want.res_den);
					if (got.cmp_true != want.cmp_true)
						report_mismatch("cmp_true", got.cmp_true, want.cmp_true);
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
				end
			end
			if ($urandom_range(0, 59) == 0) recv_burst = !recv_burst;
			if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap = recv_burst ? 0 : pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout");
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic logic [WIDTH-1:0] rand_value(logic nonzero_bias);
		int r;
		logic [WIDTH-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 45) v = WIDTH'($urandom_range(0, 40)) - WIDTH'(20);
		else if (r < 60) v = WIDTH'($urandom_range(0, 2000)) - WIDTH'(1000);
		else if (r < 90) v = WIDTH'($urandom);
		else case ($urandom_range(0, 4))
			0: v = {1'b1, {(WIDTH-1){1'b0}}};
			1: v = {1'b0, {(WIDTH-1){1'b1}}};
			2: v = '1;
			3: v = WIDTH'(1);
			default: v = '0;
		endcase
		if (nonzero_bias && v == 0 && $urandom_range(0, 3) != 0) v = WIDTH'(1);
		return v;
	endfunction

	initial begin
		fraction_op_t t;
		logic [WIDTH-1:0] min_v, max_v;
		min_v = {1'b1, {(WIDTH-1){1'b0}}};
		max_v = {1'b0, {(WIDTH-1){1'b1}}};

		// directed corners
		queue_op('{OP_REDUCE, 12, -18, 0, 1});
		queue_op('{OP_REDUCE, min_v, -1, 0, 1});
		queue_op('{OP_REDUCE, 1, min_v, 0, 1});
		queue_op('{OP_REDUCE, min_v, min_v, 0, 0});
		queue_op('{OP_REDUCE, 0, -7, 0, 0});
		queue_op('{OP_REDUCE, 5, 0, 3, 4});
		queue_op('{OP_ADD, max_v, 1, max_v, 1});
		queue_op('{OP_ADD, 1, 6, 1, 3});
		queue_op('{OP_ADD, 1, 2, -1, 2});
		queue_op('{OP_ADD, 1, 2, 3, 0});
		queue_op('{OP_SUBTRACT, min_v, 1, 1, 1});
		queue_op('{OP_SUBTRACT, 1, max_v, 1, max_v - 1});
		queue_op('{OP_MULTIPLY, min_v, 1, min_v, 1});
		queue_op('{OP_MULTIPLY, min_v, 1, -1, 1});
		queue_op('{OP_MULTIPLY, 0, 5, 3, 7});
		queue_op('{OP_DIVIDE, 3, 4, 0, 5});
		queue_op('{OP_DIVIDE, 3, 4, -9, 8});
		queue_op('{OP_DIVIDE, 1, max_v, max_v, 1});
		queue_op('{OP_EQUAL, 2, 4, -1, -2});
		queue_op('{OP_EQUAL, 0, 3, 0, -5});
		queue_op('{OP_EQUAL, 1, 2, -1, 2});
		queue_op('{OP_LESS, -1, 2, 1, 3});
		queue_op('{OP_LESS, max_v, max_v - 1, max_v - 1, max_v - 2});
		queue_op('{OP_LESS, 1, 0, 1, 1});
		queue_op('{OP_UNUSED, 7, 0, 3, 0});

		repeat (850) begin
			t.op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
			t.a_num = rand_value(1'b0);
			t.a_den = rand_value(1'b1);
			t.b_num = rand_value(t.op == OP_DIVIDE);
			t.b_den = rand_value(1'b1);
			queue_op(t);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (300) @(posedge clk);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
